[sv/u8cp_pkg.sv]
// Shared types and constants for the UTF-8 code point lookup block.
`timescale 1ns / 1ps

package u8cp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CHAR_W   = 16;

    // Lead byte masks and patterns.
    localparam logic [7:0] LEAD1_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] PAY2_MASK  = 8'h1F;
    localparam logic [7:0] PAY3_MASK  = 8'h0F;
    localparam logic [7:0] PAY4_MASK  = 8'h07;
    localparam logic [7:0] CONT_MASK  = 8'h3F;

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_SCAN    = 3'd1,
        PH_SKIP    = 3'd2,
        PH_COLLECT = 3'd3,
        PH_SWALLOW = 3'd4
    } t_phase;

    // Classification of one string byte, produced by the front end.
    typedef struct packed {
        logic       is_nul;
        logic [2:0] len;       // 0 for a byte that cannot start a character
        logic [6:0] payload;   // payload bits of a lead byte
        logic [7:0] data_byte;
    } t_byte_class;

endpackage

[sv/u8cp_front.sv]
// Front end: accepts string bytes and classifies them as lead bytes.
`timescale 1ns / 1ps

module u8cp_front #(
    parameter int unsigned INDEX_BITS = 16
) (
    input  logic [7:0]             i_data_byte,
    input  logic [15:0]            i_char_index,
    output u8cp_pkg::t_byte_class  o_class,
    output logic [INDEX_BITS-1:0]  o_index
);

    always_comb begin
        o_class           = '0;
        o_class.data_byte = i_data_byte;
        o_class.is_nul    = (i_data_byte == 8'h00);
        priority if ((i_data_byte & u8cp_pkg::LEAD1_MASK) == 8'h00) begin
            o_class.len     = 3'd1;
            o_class.payload = i_data_byte[6:0];
        end else if ((i_data_byte & u8cp_pkg::LEAD2_MASK) == u8cp_pkg::LEAD2_PAT) begin
            o_class.len     = 3'd2;
            o_class.payload = {2'b00, i_data_byte[4:0] & u8cp_pkg::PAY2_MASK[4:0]};
        end else if ((i_data_byte & u8cp_pkg::LEAD3_MASK) == u8cp_pkg::LEAD3_PAT) begin
            o_class.len     = 3'd3;
            o_class.payload = {3'b000, i_data_byte[3:0] & u8cp_pkg::PAY3_MASK[3:0]};
        end else if ((i_data_byte & u8cp_pkg::LEAD4_MASK) == u8cp_pkg::LEAD4_PAT) begin
            o_class.len     = 3'd4;
            o_class.payload = {4'b0000, i_data_byte[2:0] & u8cp_pkg::PAY4_MASK[2:0]};
        end else begin
            o_class.len     = 3'd0;
            o_class.payload = 7'd0;
        end
    end

    // The index travels with every item; the back end samples it at string start.
    generate
        if (INDEX_BITS > 16) begin : g_wide
            assign o_index = {{(INDEX_BITS-16){1'b0}}, i_char_index};
        end else if (INDEX_BITS == 16) begin : g_same
            assign o_index = i_char_index;
        end else begin : g_narrow
            assign o_index = i_char_index[INDEX_BITS-1:0];
        end
    endgenerate

endmodule

[sv/u8cp_fifo.sv]
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps

module u8cp_fifo #(
    parameter int unsigned WIDTH = 34
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[sv/u8cp_back.sv]
// Back end: character counting, code point assembly and the result register.
`timescale 1ns / 1ps

module u8cp_back #(
    parameter int unsigned INDEX_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  u8cp_pkg::t_byte_class               i_class,
    input  logic [INDEX_BITS-1:0]               i_index,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [u8cp_pkg::CP_W-1:0]           o_char_val,
    output logic [u8cp_pkg::STATUS_W-1:0]       o_status
);

    u8cp_pkg::t_phase                r_phase,  n_phase;
    logic [1:0]                      r_bytes_left, n_bytes_left;
    logic [INDEX_BITS-1:0]           r_chars_seen, n_chars_seen;
    logic [INDEX_BITS-1:0]           r_wanted, n_wanted;
    logic [u8cp_pkg::CP_W-1:0]       r_acc, n_acc;
    logic                            r_out_valid;
    logic [u8cp_pkg::CP_W-1:0]       r_char_val;
    logic [u8cp_pkg::STATUS_W-1:0]   r_status;
    logic                            w_emit;
    logic [u8cp_pkg::CP_W-1:0]       w_cp;
    logic [u8cp_pkg::STATUS_W-1:0]   w_st;
    u8cp_pkg::t_phase                w_cur;
    logic [1:0]                      w_bl_dec;

    // A new item may enter whenever the result register is free or being drained.
    assign o_pop        = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid  = r_out_valid;
    assign o_char_val   = r_char_val;
    assign o_status     = r_status;

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_chars_seen = r_chars_seen;
        n_wanted     = r_wanted;
        n_acc        = r_acc;
        w_emit       = 1'b0;
        w_cp         = '0;
        w_st         = u8cp_pkg::ST_FOUND;
        w_cur        = r_phase;

        // The first byte of a string samples the index and clears the counters.
        if (r_phase == u8cp_pkg::PH_START) begin
            n_wanted     = i_index;
            n_chars_seen = '0;
            n_bytes_left = 2'd0;
            n_acc        = '0;
            w_cur        = u8cp_pkg::PH_SCAN;
        end
        w_bl_dec = n_bytes_left - 2'd1;

        unique case (w_cur)
            u8cp_pkg::PH_SCAN: begin
                n_phase = u8cp_pkg::PH_SCAN;
                if (i_class.is_nul) begin
                    n_phase = u8cp_pkg::PH_START;
                    w_emit  = 1'b1;
                    w_st    = u8cp_pkg::ST_RANGE;
                end else if (i_class.len != 3'd0) begin
                    if (n_chars_seen == n_wanted) begin
                        if (i_class.len == 3'd1) begin
                            n_phase = u8cp_pkg::PH_SWALLOW;
                            w_emit  = 1'b1;
                            w_cp    = {14'd0, i_class.payload};
                        end else begin
                            n_acc        = {14'd0, i_class.payload};
                            n_bytes_left = i_class.len[1:0] - 2'd1;
                            n_phase      = u8cp_pkg::PH_COLLECT;
                        end
                    end else begin
                        if (n_chars_seen != '1) begin
                            n_chars_seen = n_chars_seen + INDEX_BITS'(1);
                        end
                        if (i_class.len != 3'd1) begin
                            n_bytes_left = i_class.len[1:0] - 2'd1;
                            n_phase      = u8cp_pkg::PH_SKIP;
                        end
                    end
                end
            end
            u8cp_pkg::PH_SKIP: begin
                if (i_class.is_nul) begin
                    n_bytes_left = 2'd0;
                    n_phase      = u8cp_pkg::PH_START;
                    w_emit       = 1'b1;
                    w_st         = u8cp_pkg::ST_RANGE;
                end else begin
                    n_bytes_left = w_bl_dec;
                    if (w_bl_dec == 2'd0) begin
                        n_phase = u8cp_pkg::PH_SCAN;
                    end
                end
            end
            u8cp_pkg::PH_COLLECT: begin
                if (i_class.is_nul) begin
                    n_bytes_left = 2'd0;
                    n_phase      = u8cp_pkg::PH_START;
                    w_emit       = 1'b1;
                    w_cp         = u8cp_pkg::REPLACEMENT;
                    w_st         = u8cp_pkg::ST_TRUNC;
                end else begin
                    // Trailing bytes are taken as they come, without a continuation check.
                    n_acc = {n_acc[14:0],
                             i_class.data_byte[5:0] & u8cp_pkg::CONT_MASK[5:0]};
                    n_bytes_left = w_bl_dec;
                    if (w_bl_dec == 2'd0) begin
                        n_phase = u8cp_pkg::PH_SWALLOW;
                        w_emit  = 1'b1;
                        w_cp    = n_acc;
                    end
                end
            end
            default: begin
                if (i_class.is_nul) begin
                    n_phase = u8cp_pkg::PH_START;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= u8cp_pkg::PH_START;
            r_bytes_left <= 2'd0;
            r_chars_seen <= '0;
            r_wanted     <= '0;
            r_acc        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_chars_seen <= n_chars_seen;
                r_wanted     <= n_wanted;
                r_acc        <= n_acc;
            end
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_char_val <= w_cp;
            r_status   <= w_st;
        end
    end

`ifndef SYNTHESIS
    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_class.is_nul) |=> (r_phase == u8cp_pkg::PH_START))
        else $error("NUL item did not return the decoder to string start");

    a_trunc_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == u8cp_pkg::ST_TRUNC)
            |-> (r_char_val == u8cp_pkg::REPLACEMENT))
        else $error("truncated result without replacement code point");

    a_range_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == u8cp_pkg::ST_RANGE) |-> (r_char_val == '0))
        else $error("out-of-range result with nonzero code point");

    a_trail_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == u8cp_pkg::PH_SKIP || r_phase == u8cp_pkg::PH_COLLECT)
            |-> (r_bytes_left != 2'd0))
        else $error("multi-byte character phase with no trailing bytes due");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result was lost while stalled");
`endif

endmodule

[sv/utf8_code_point_at_index.sv]
// Top level of the UTF-8 code point lookup at a character index.
`timescale 1ns / 1ps

// Streams a NUL-terminated UTF-8 string in, one byte per item, and returns the
// code point of the character at the index sampled with the string's first
// byte: status found, truncated (0xFFFD, NUL inside the wanted character) or
// out of range (0, NUL before the wanted character). Invalid lead bytes are
// skipped and not counted; bytes after a result are dropped up to the NUL.
// The block takes one byte every clock cycle while its queue has room. A byte
// passes the classifier into a two-entry queue and is processed from there by
// the counting and assembly stage, which registers the result when it takes the
// byte that completes it. While a result waits to be taken the back end
// holds, and the queue absorbs up to two more bytes before the input stalls; the
// input ready comes from the queue's registered fill count after that.
module utf8_code_point_at_index #(
    parameter int unsigned INDEX_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] data_byte, [23:8] char_index
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [20:0] code point, [22:21] status, [23] zero
);

    localparam int unsigned QW = INDEX_BITS + $bits(u8cp_pkg::t_byte_class);

    u8cp_pkg::t_byte_class                w_class;
    u8cp_pkg::t_byte_class                w_q_class;
    logic [INDEX_BITS-1:0]                w_index;
    logic [INDEX_BITS-1:0]                w_q_index;
    logic [QW-1:0]                        w_q_out;
    logic                                 w_full;
    logic                                 w_q_valid;
    logic                                 w_pop;
    logic [u8cp_pkg::CP_W-1:0]            w_char_val;
    logic [u8cp_pkg::STATUS_W-1:0]        w_status;

    u8cp_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_data_byte  (i_s_tdata[7:0]),
        .i_char_index (i_s_tdata[23:8]),
        .o_class      (w_class),
        .o_index      (w_index)
    );

    u8cp_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_data  ({w_index, w_class}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    assign o_s_tready = !w_full;
    assign w_q_class  = w_q_out[$bits(u8cp_pkg::t_byte_class)-1:0];
    assign w_q_index  = w_q_out[QW-1:$bits(u8cp_pkg::t_byte_class)];

    u8cp_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_class      (w_q_class),
        .i_index      (w_q_index),
        .o_pop        (w_pop),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_char_val   (w_char_val),
        .o_status     (w_status)
    );

    assign o_m_tdata = {1'b0, w_status, w_char_val};

endmodule

[tb/sv/utf8_lookup_checker.sv]
// Checker that predicts and compares the results of the UTF-8 code point lookup.
`timescale 1ns / 1ps

module utf8_lookup_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] data_byte, [23:8] char_index
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [20:0] code point, [22:21] status, [23] zero
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [u8cp_pkg::CP_W-1:0]     char_val;
        logic [u8cp_pkg::STATUS_W-1:0] status;
    } t_lookup;

    // Our own copy of the decoder state.
    u8cp_pkg::t_phase            scan_phase;
    logic [1:0]                  trail_left;
    logic [u8cp_pkg::CHAR_W-1:0] char_count;
    logic [u8cp_pkg::CHAR_W-1:0] goal_index;
    logic [u8cp_pkg::CP_W-1:0]   cp_acc;

    t_lookup lookups_due[$];
    int      fails;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fails        = 0;
    end

    task automatic queue_lookup(input logic [u8cp_pkg::CP_W-1:0] cp,
                                input logic [u8cp_pkg::STATUS_W-1:0] st);
        t_lookup r;
        r.char_val = cp;
        r.status   = st;
        lookups_due.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] b,
                               input logic [u8cp_pkg::CHAR_W-1:0] idx);
        logic [2:0]                len;
        logic [u8cp_pkg::CP_W-1:0] pay;
        if (scan_phase == u8cp_pkg::PH_START) begin
            goal_index = idx;
            char_count = '0;
            trail_left = '0;
            cp_acc     = '0;
            scan_phase = u8cp_pkg::PH_SCAN;
        end
        case (scan_phase)
            u8cp_pkg::PH_SCAN: begin
                if (b == 8'h00) begin
                    scan_phase = u8cp_pkg::PH_START;
                    queue_lookup('0, u8cp_pkg::ST_RANGE);
                end else begin
                    pay = '0;
                    if ((b & u8cp_pkg::LEAD1_MASK) == 8'h00) begin
                        len = 3'd1;
                        pay = {13'd0, b};
                    end else if ((b & u8cp_pkg::LEAD2_MASK) == u8cp_pkg::LEAD2_PAT) begin
                        len = 3'd2;
                        pay = {13'd0, b & u8cp_pkg::PAY2_MASK};
                    end else if ((b & u8cp_pkg::LEAD3_MASK) == u8cp_pkg::LEAD3_PAT) begin
                        len = 3'd3;
                        pay = {13'd0, b & u8cp_pkg::PAY3_MASK};
                    end else if ((b & u8cp_pkg::LEAD4_MASK) == u8cp_pkg::LEAD4_PAT) begin
                        len = 3'd4;
                        pay = {13'd0, b & u8cp_pkg::PAY4_MASK};
                    end else begin
                        len = 3'd0;
                    end
                    // A byte that cannot start a character is dropped without counting.
                    if (len != 3'd0) begin
                        if (char_count == goal_index) begin
                            if (len == 3'd1) begin
                                scan_phase = u8cp_pkg::PH_SWALLOW;
                                queue_lookup(pay, u8cp_pkg::ST_FOUND);
                            end else begin
                                cp_acc     = pay;
                                trail_left = 2'(len - 3'd1);
                                scan_phase = u8cp_pkg::PH_COLLECT;
                            end
                        end else begin
                            if (char_count != '1)
                                char_count = char_count + 16'd1;
                            if (len > 3'd1) begin
                                trail_left = 2'(len - 3'd1);
                                scan_phase = u8cp_pkg::PH_SKIP;
                            end
                        end
                    end
                end
            end
            u8cp_pkg::PH_SKIP: begin
                if (b == 8'h00) begin
                    trail_left = '0;
                    scan_phase = u8cp_pkg::PH_START;
                    queue_lookup('0, u8cp_pkg::ST_RANGE);
                end else begin
                    trail_left = trail_left - 2'd1;
                    if (trail_left == 2'd0)
                        scan_phase = u8cp_pkg::PH_SCAN;
                end
            end
            u8cp_pkg::PH_COLLECT: begin
                if (b == 8'h00) begin
                    trail_left = '0;
                    scan_phase = u8cp_pkg::PH_START;
                    queue_lookup(u8cp_pkg::REPLACEMENT, u8cp_pkg::ST_TRUNC);
                end else begin
                    cp_acc     = {cp_acc[u8cp_pkg::CP_W-7:0], b[5:0]};
                    trail_left = trail_left - 2'd1;
                    if (trail_left == 2'd0) begin
                        scan_phase = u8cp_pkg::PH_SWALLOW;
                        queue_lookup(cp_acc, u8cp_pkg::ST_FOUND);
                    end
                end
            end
            default: begin
                if (b == 8'h00)
                    scan_phase = u8cp_pkg::PH_START;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            scan_phase = u8cp_pkg::PH_START;
            trail_left = '0;
            char_count = '0;
            goal_index = '0;
            cp_acc     = '0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                decode_byte(i_s_tdata[7:0], i_s_tdata[23:8]);
            if (i_m_tvalid && i_m_tready) begin
                if (lookups_due.size() == 0) begin
                    fails++;
                    $display("%0t checker: unexpected result, expected none, got cp %h status %0d",
                             $time, i_m_tdata[20:0], i_m_tdata[22:21]);
                end else begin
                    want = lookups_due.pop_front();
                    if (i_m_tdata[20:0] !== want.char_val) begin
                        fails++;
                        $display("%0t checker: code point mismatch, expected %h, got %h",
                                 $time, want.char_val, i_m_tdata[20:0]);
                    end
                    if (i_m_tdata[22:21] !== want.status) begin
                        fails++;
                        $display("%0t checker: status mismatch, expected %0d, got %0d",
                                 $time, want.status, i_m_tdata[22:21]);
                    end
                    if (i_m_tdata[23] !== 1'b0) begin
                        fails++;
                        $display("%0t checker: pad bit mismatch, expected 0, got %b",
                                 $time, i_m_tdata[23]);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= lookups_due.size();
    end

endmodule

[tb/sv/testbench.sv]
// Top of the testbench: clock, reset, byte stream stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 600000;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [23:0] i_s_tdata  = '0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;

    int fail_count;
    int pending;
    int cycles = 0;
    int ready_hold = 0;
    int sent_items = 0;

    logic [7:0] str_bytes[$];

    utf8_code_point_at_index #(
        .INDEX_BITS(16)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    utf8_lookup_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: mostly ready, short and long stalls, and long stall-free stretches.
    always @(posedge i_clk) begin
        int pick;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                i_m_tready <= 1'b1;
                ready_hold <= $urandom_range(1, 20);
            end else if (pick < 90) begin
                i_m_tready <= 1'b0;
                ready_hold <= $urandom_range(1, 3);
            end else if (pick < 97) begin
                i_m_tready <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end else begin
                i_m_tready <= 1'b1;
                ready_hold <= $urandom_range(50, 200);
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // The ready flag comes straight from a register, so its mid-cycle value is the
    // one seen at the next rising edge.
    task automatic send_byte(input logic [7:0] b, input logic [15:0] idx, input int gap);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {idx, b};
        @(negedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        sent_items++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The index rides on the first byte only; later bytes carry random noise there.
    task automatic send_string(input logic [15:0] idx, input bit no_gaps);
        int gap;
        for (int i = 0; i < str_bytes.size(); i++) begin
            gap = no_gaps ? 0 : pick_gap();
            send_byte(str_bytes[i], (i == 0) ? idx : 16'($urandom_range(0, 65535)), gap);
        end
    endtask

    function automatic logic [7:0] trail_byte();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(1, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Builds a mostly well-formed string and returns a fitting index for it.
    function automatic logic [15:0] build_string();
        int nchars;
        int len;
        int pick;
        int cut;
        logic [15:0] idx;
        str_bytes.delete();
        nchars = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        for (int c = 0; c < nchars; c++) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                else
                    str_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            end
            len = $urandom_range(1, 4);
            case (len)
                1: str_bytes.push_back(8'($urandom_range(1, 127)));
                2: str_bytes.push_back(u8cp_pkg::LEAD2_PAT | 8'($urandom_range(0, 31)));
                3: str_bytes.push_back(u8cp_pkg::LEAD3_PAT | 8'($urandom_range(0, 15)));
                default: str_bytes.push_back(u8cp_pkg::LEAD4_PAT | 8'($urandom_range(0, 7)));
            endcase
            for (int t = 1; t < len; t++)
                str_bytes.push_back(trail_byte());
        end
        // Cutting the string short puts the NUL inside a character now and then.
        if (str_bytes.size() > 0 && $urandom_range(0, 6) == 0) begin
            cut = $urandom_range(0, str_bytes.size() - 1);
            while (str_bytes.size() > cut)
                void'(str_bytes.pop_back());
        end
        str_bytes.push_back(8'h00);
        pick = $urandom_range(0, 9);
        if (pick < 8)
            idx = 16'($urandom_range(0, nchars + 1));
        else
            idx = 16'($urandom_range(0, 65535));
        return idx;
    endfunction

    task automatic send_noise_string();
        str_bytes.delete();
        repeat ($urandom_range(0, 15))
            str_bytes.push_back(8'($urandom_range(1, 255)));
        str_bytes.push_back(8'h00);
        send_string(16'($urandom_range(0, 65535)), $urandom_range(0, 4) == 0);
    endtask

    initial begin
        logic [15:0] idx;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty string.
        str_bytes = '{8'h00};
        send_string(16'h0000, 1'b0);
        // Largest one-byte character.
        str_bytes = '{8'h7F, 8'h00};
        send_string(16'h0000, 1'b0);
        // Four-byte character with every payload bit set.
        str_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00};
        send_string(16'h0000, 1'b0);
        // Invalid lead bytes are dropped without counting.
        str_bytes = '{8'hFF, 8'h80, 8'hC3, 8'hA9, 8'h00};
        send_string(16'h0000, 1'b0);
        // Largest index, past the end.
        str_bytes = '{8'h61, 8'h00};
        send_string(16'hFFFF, 1'b0);
        // NUL inside a character that is being skipped.
        str_bytes = '{8'hE2, 8'h82, 8'h00};
        send_string(16'h0001, 1'b0);
        // NUL inside the wanted character.
        str_bytes = '{8'h41, 8'hE2, 8'h82, 8'h00};
        send_string(16'h0001, 1'b0);
        // Trailing bytes that are not continuation bytes are still assembled.
        str_bytes = '{8'hE0, 8'h41, 8'hC0, 8'h00};
        send_string(16'h0000, 1'b0);

        while (sent_items < RANDOM_ITEMS + 30) begin
            if ($urandom_range(0, 4) == 0) begin
                send_noise_string();
            end else begin
                idx = build_string();
                send_string(idx, $urandom_range(0, 4) == 0);
            end
        end
        str_bytes.delete();

        i_s_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
